FILE: rtl/core/ssir_pkg.sv
// ----------------------------------------------------------------------------
// ssir_pkg: shared types and constants of the sorted set engine
// Field widths, operation codes, sequencer states and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ssir_pkg;

  // payload widths
  localparam int unsigned ID_W    = 32;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned VER_W   = 32;

  // default number of cells in the chain
  localparam int unsigned DEF_CAPACITY = 256;

  // match flags folded per group in the first tree level
  localparam int unsigned GRP_SIZE = 16;

  // operation codes
  typedef enum logic [0:0] {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CMP   = 2'd1,
    ST_RED   = 2'd2,
    ST_APPLY = 2'd3
  } state_e;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic add_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssir_cell.sv
// ----------------------------------------------------------------------------
// ssir_cell: one slot of the sorted chain
// Holds one identifier, compares it with the broadcast key and takes the key or
// its lower neighbor's entry on an insert, or its upper neighbor's entry on a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module ssir_cell #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned FillW = 9
) (
  input  wire logic                         clk_i,
  input  wire logic [ssir_pkg::ID_W-1:0]    key_i,
  input  wire ssir_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [FillW-1:0]             fill_i,
  input  wire logic [ssir_pkg::ID_W-1:0]    lo_entry_i,
  input  wire logic                         lo_lt_i,
  input  wire logic [ssir_pkg::ID_W-1:0]    hi_entry_i,
  output logic      [ssir_pkg::ID_W-1:0]    entry_o,
  output logic                              lt_o,
  output logic                              eq_o
);

  logic [ssir_pkg::ID_W-1:0] entry_q, entry_d;
  logic                      lt_q, eq_q;
  logic                      valid;

  // slot holds a live entry when it sits below the fill level
  assign valid = (fill_i > FillW'(Idx));

  // compare flags, sampled once per operation
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      lt_q <= valid && (entry_q < key_i);
      eq_q <= valid && (entry_q == key_i);
    end
  end

  // shift decision: slots at or above the key position move
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.add_en && !lt_q) begin
      entry_d = lo_lt_i ? key_i : lo_entry_i;
    end else if (ctrl_i.rem_en && !lt_q) begin
      entry_d = hi_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

FILE: rtl/core/ssir_hit_tree.sv
// ----------------------------------------------------------------------------
// ssir_hit_tree: registered OR of the per-cell match flags
// First level folds groups into registers, the second level ORs the groups.
// ----------------------------------------------------------------------------
`default_nettype none

module ssir_hit_tree #(
  parameter int unsigned N = ssir_pkg::DEF_CAPACITY
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [N-1:0] eq_i,
  output logic              hit_o
);

  localparam int unsigned G    = ssir_pkg::GRP_SIZE;
  localparam int unsigned NGRP = (N + G - 1) / G;

  logic [NGRP*G-1:0] pad;
  logic [NGRP-1:0]   grp_d, grp_q;

  assign pad = (NGRP*G)'(eq_i);

  // group level
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = |pad[g*G +: G];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  // final level
  assign hit_o = |grp_q;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_set_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_remove: ordered set of distinct identifiers
// Chain of compare-and-shift cells, one per slot, with a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | content
//  in      | in_valid_i / in_ready_o          | input     | func_i, id_i
//  out     | out_valid_o / out_ready_i        | output    | ok_o, count_o, version_o
//
//  Each item goes through accept, compare in every cell, fold the match
//  flags through the registered OR tree, then decide and shift the chain.
//  in_ready_o is high only while the sequencer is idle.
//  A result waiting in the output register stalls only the shift step.
//  Reset clears fill level, version and control; cell contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_insert_remove #(
  parameter int unsigned CAPACITY = ssir_pkg::DEF_CAPACITY
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           func_i,
  input  wire logic [ssir_pkg::ID_W-1:0]      id_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                ok_o,
  output logic      [ssir_pkg::COUNT_W-1:0]   count_o,
  output logic      [ssir_pkg::VER_W-1:0]     version_o
);

  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

  ssir_pkg::state_e          state_q, state_d;
  ssir_pkg::func_e           func_q;
  logic [ssir_pkg::ID_W-1:0] key_q;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic [ssir_pkg::VER_W-1:0] ver_q, ver_d;
  logic                      out_valid_q, out_valid_d;
  logic                      ok_q;
  logic [ssir_pkg::COUNT_W-1:0] count_q;
  logic [ssir_pkg::VER_W-1:0]   version_q;

  ssir_pkg::cell_ctrl_t      ctrl;
  logic                      in_xfer, commit, hit, ok_c, red_en;

  logic [ssir_pkg::ID_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]       lt_vec, eq_vec;

  assign in_xfer = in_valid_i && in_ready_o;
  assign commit  = (state_q == ssir_pkg::ST_APPLY) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssir_pkg::ST_IDLE:  if (in_xfer) state_d = ssir_pkg::ST_CMP;
      ssir_pkg::ST_CMP:   state_d = ssir_pkg::ST_RED;
      ssir_pkg::ST_RED:   state_d = ssir_pkg::ST_APPLY;
      ssir_pkg::ST_APPLY: if (commit) state_d = ssir_pkg::ST_IDLE;
      default:            state_d = ssir_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    red_en      = 1'b0;
    ctrl        = '0;
    unique case (state_q)
      ssir_pkg::ST_IDLE: in_ready_o = 1'b1;
      ssir_pkg::ST_CMP:  ctrl.cmp_en = 1'b1;
      ssir_pkg::ST_RED:  red_en = 1'b1;
      ssir_pkg::ST_APPLY: begin
        ctrl.add_en = commit && ok_c && (func_q == ssir_pkg::FUNC_ADD);
        ctrl.rem_en = commit && ok_c && (func_q == ssir_pkg::FUNC_REMOVE);
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssir_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= ssir_pkg::func_e'(func_i);
      key_q  <= id_i;
    end
  end

  // chain of cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ssir_pkg::ID_W-1:0] lo_entry, hi_entry;
    logic                      lo_lt;

    if (k == 0) begin : g_lo_edge
      assign lo_entry = entries[k];
      assign lo_lt    = 1'b1;
    end else begin : g_lo
      assign lo_entry = entries[k-1];
      assign lo_lt    = lt_vec[k-1];
    end

    if (k == CAPACITY - 1) begin : g_hi_edge
      assign hi_entry = entries[k];
    end else begin : g_hi
      assign hi_entry = entries[k+1];
    end

    ssir_cell #(
      .Idx   (k),
      .FillW (FILL_W)
    ) u_cell (
      .clk_i      (clk_i),
      .key_i      (key_q),
      .ctrl_i     (ctrl),
      .fill_i     (fill_q),
      .lo_entry_i (lo_entry),
      .lo_lt_i    (lo_lt),
      .hi_entry_i (hi_entry),
      .entry_o    (entries[k]),
      .lt_o       (lt_vec[k]),
      .eq_o       (eq_vec[k])
    );
  end

  // presence of the key anywhere in the set
  ssir_hit_tree #(
    .N (CAPACITY)
  ) u_hit_tree (
    .clk_i (clk_i),
    .en_i  (red_en),
    .eq_i  (eq_vec),
    .hit_o (hit)
  );

  // accept or refuse the change
  assign ok_c = (func_q == ssir_pkg::FUNC_ADD) ? (!hit && (fill_q != FILL_W'(CAPACITY)))
                                               : hit;

  always_comb begin
    fill_d = fill_q;
    ver_d  = ver_q;
    if (commit && ok_c) begin
      fill_d = (func_q == ssir_pkg::FUNC_ADD) ? fill_q + FILL_W'(1) : fill_q - FILL_W'(1);
      ver_d  = ver_q + ssir_pkg::VER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ver_q  <= '0;
    end else begin
      fill_q <= fill_d;
      ver_q  <= ver_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      ok_q      <= ok_c;
      count_q   <= ssir_pkg::COUNT_W'(fill_d);
      version_q <= ver_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign count_o     = count_q;
  assign version_o   = version_q;

endmodule

`default_nettype wire

FILE: rtl/core/ssir_checker.sv
// ----------------------------------------------------------------------------
// ssir_checker: port-level checks of the sorted set engine
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssir_checker #(
  parameter int unsigned CAPACITY = ssir_pkg::DEF_CAPACITY
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           ok_o,
  input wire logic [ssir_pkg::COUNT_W-1:0]   count_o,
  input wire logic [ssir_pkg::VER_W-1:0]     version_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o) && $stable(count_o)
                                    && $stable(version_o))
    else $error("result changed while stalled");

  // engine is busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while previous one in flight");

  // a fresh result only follows a busy cycle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in flight");

  // fill level never exceeds the chain length
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= ssir_pkg::COUNT_W'(CAPACITY)) || (CAPACITY > 511))
    else $error("count above capacity");

endmodule

bind sorted_set_insert_remove ssir_checker #(
  .CAPACITY (CAPACITY)
) u_ssir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .ok_o        (ok_o),
  .count_o     (count_o),
  .version_o   (version_o)
);

`default_nettype wire
